// ===== rtl/core/kbd_pkg.sv =====
package kbd_pkg;

	// Command codes carried by an input item.
	localparam logic [1:0] CMD_KEY   = 2'd0;
	localparam logic [1:0] CMD_TABLE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Key action codes.
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;

	// Configuration register indexes.
	localparam logic CFG_CAPS = 1'b0;
	localparam logic CFG_NUM  = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_IGNORED   = 3'd0;
	localparam logic [2:0] ST_APPENDED  = 3'd1;
	localparam logic [2:0] ST_ERASED    = 3'd2;
	localparam logic [2:0] ST_ENTERED   = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_DROPPED   = 3'd5;
	localparam logic [2:0] ST_CLOSED    = 3'd6;
	localparam logic [2:0] ST_DONE      = 3'd7;

	// Key codes that the block acts on.
	localparam logic [7:0] K_ESC       = 8'd1;
	localparam logic [7:0] K_1         = 8'd2;
	localparam logic [7:0] K_2         = 8'd3;
	localparam logic [7:0] K_3         = 8'd4;
	localparam logic [7:0] K_4         = 8'd5;
	localparam logic [7:0] K_5         = 8'd6;
	localparam logic [7:0] K_6         = 8'd7;
	localparam logic [7:0] K_7         = 8'd8;
	localparam logic [7:0] K_8         = 8'd9;
	localparam logic [7:0] K_9         = 8'd10;
	localparam logic [7:0] K_0         = 8'd11;
	localparam logic [7:0] K_MINUS     = 8'd12;
	localparam logic [7:0] K_EQUAL     = 8'd13;
	localparam logic [7:0] K_BACKSPACE = 8'd14;
	localparam logic [7:0] K_ENTER     = 8'd28;
	localparam logic [7:0] K_GRAVE     = 8'd41;
	localparam logic [7:0] K_LSHIFT    = 8'd42;
	localparam logic [7:0] K_DOT       = 8'd52;
	localparam logic [7:0] K_SLASH     = 8'd53;
	localparam logic [7:0] K_RSHIFT    = 8'd54;
	localparam logic [7:0] K_CAPS      = 8'd58;
	localparam logic [7:0] K_NUM       = 8'd69;
	localparam logic [7:0] K_DELETE    = 8'd111;

	// Keypad key codes.
	localparam logic [7:0] KP_7     = 8'd71;
	localparam logic [7:0] KP_8     = 8'd72;
	localparam logic [7:0] KP_9     = 8'd73;
	localparam logic [7:0] KP_MINUS = 8'd74;
	localparam logic [7:0] KP_4     = 8'd75;
	localparam logic [7:0] KP_5     = 8'd76;
	localparam logic [7:0] KP_6     = 8'd77;
	localparam logic [7:0] KP_PLUS  = 8'd78;
	localparam logic [7:0] KP_1     = 8'd79;
	localparam logic [7:0] KP_2     = 8'd80;
	localparam logic [7:0] KP_3     = 8'd81;
	localparam logic [7:0] KP_0     = 8'd82;
	localparam logic [7:0] KP_DOT   = 8'd83;
	localparam logic [7:0] KP_ASTER = 8'd55;
	localparam logic [7:0] KP_ENTER = 8'd96;
	localparam logic [7:0] KP_SLASH = 8'd98;

	// Table entry layout: valid flag over the code point.
	localparam int CHAR_W   = 21;
	localparam int ENTRY_W  = 22;
	localparam int VALID_AT = 21;

	// What the second stage does with an item.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLOSED,
		OP_LOOKUP,
		OP_ERASE,
		OP_ENTER,
		OP_CANCEL,
		OP_DROP,
		OP_TABLE,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic     done;
	} kbd_op_t;

	typedef struct packed {
		logic       forced;
		logic       fshift;
		logic [7:0] code;
	} kp_map_t;

	// Keypad keys fold onto main keys; a folded key has its shift forced.
	function automatic kp_map_t kp_map(input logic [7:0] code);
		kp_map_t r;
		r.forced = 1'b1;
		r.fshift = 1'b0;
		r.code   = code;
		unique case (code)
			KP_0:     r.code = K_0;
			KP_1:     r.code = K_1;
			KP_2:     r.code = K_2;
			KP_3:     r.code = K_3;
			KP_4:     r.code = K_4;
			KP_5:     r.code = K_5;
			KP_6:     r.code = K_6;
			KP_7:     r.code = K_7;
			KP_8:     r.code = K_8;
			KP_9:     r.code = K_9;
			KP_SLASH: r.code = K_SLASH;
			KP_ASTER: begin
				r.code   = K_8;
				r.fshift = 1'b1;
			end
			KP_MINUS: r.code = K_MINUS;
			KP_PLUS: begin
				r.code   = K_EQUAL;
				r.fshift = 1'b1;
			end
			KP_DOT:   r.code = K_DOT;
			KP_ENTER: r.code = K_ENTER;
			default:  r.forced = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/kbd_ram.sv =====
module kbd_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/kbd_front.sv =====
module kbd_front #(
	parameter int CODE_COUNT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic                           cfg_data,
	input  logic                           acc,
	input  logic [1:0]                     cmd,
	input  logic [7:0]                     key_code,
	input  logic [1:0]                     key_action,
	input  logic [8:0]                     table_index,
	input  logic [20:0]                    table_char,
	input  logic                           table_valid,
	output kbd_pkg::kbd_op_t               op,
	output logic [kbd_pkg::ENTRY_W-1:0]    tbl_rdata
);
	import kbd_pkg::*;

	localparam int TBL_DEPTH = 2 * CODE_COUNT;
	localparam int TA        = $clog2(TBL_DEPTH);

	logic    shift_q;
	logic    caps_q;
	logic    num_q;
	logic    finished_q;
	kp_map_t kp;
	logic    sh;
	logic    cp;
	logic    live_press;
	logic    live_release;
	logic    is_shift;
	logic    tbl_we;
	logic    tbl_re;
	logic [TA-1:0] tbl_raddr;

	// Modifiers act only on a key item of an entry still open.
	assign live_press   = (cmd == CMD_KEY) && !finished_q && (key_action == ACT_PRESS);
	assign live_release = (cmd == CMD_KEY) && !finished_q && (key_action == ACT_RELEASE);
	assign is_shift     = (key_code == K_LSHIFT) || (key_code == K_RSHIFT);

	// Keypad folding and the case bit for the table lookup.
	always_comb begin
		kp = kp_map(key_code);
		sh = kp.forced ? kp.fshift : shift_q;
		cp = kp.forced ? 1'b0 : caps_q;
		if (((kp.code >= K_1) && (kp.code <= K_EQUAL)) || (kp.code == K_GRAVE)) begin
			cp = 1'b0;
		end
	end

	// Classify the item for the second stage.
	always_comb begin
		op.kind = OP_NONE;
		priority if (cmd == CMD_TABLE) begin
			op.kind = OP_TABLE;
		end else if (cmd == CMD_READ) begin
			op.kind = OP_READ;
		end else if (cmd != CMD_KEY) begin
			op.kind = OP_NONE;
		end else if (finished_q) begin
			op.kind = OP_CLOSED;
		end else if (key_action != ACT_PRESS) begin
			op.kind = OP_NONE;
		end else if (is_shift || (key_code == K_CAPS) || (key_code == K_NUM)) begin
			op.kind = OP_NONE;
		end else if (kp.code == K_ENTER) begin
			op.kind = OP_ENTER;
		end else if (kp.code == K_ESC) begin
			op.kind = OP_CANCEL;
		end else if ((kp.code == K_BACKSPACE) || (kp.code == K_DELETE)) begin
			op.kind = OP_ERASE;
		end else if ({1'b0, kp.code} >= 9'(CODE_COUNT)) begin
			op.kind = OP_DROP;
		end else begin
			op.kind = OP_LOOKUP;
		end
		op.done = finished_q || (op.kind == OP_ENTER) || (op.kind == OP_CANCEL);
	end

	// Modifier and entry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= 1'b0;
			caps_q     <= 1'b0;
			num_q      <= 1'b0;
			finished_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CFG_CAPS)) begin
				caps_q <= cfg_data;
			end else if (acc && live_press && (key_code == K_CAPS)) begin
				caps_q <= ~caps_q;
			end
			if (cfg_we && (cfg_index == CFG_NUM)) begin
				num_q <= cfg_data;
			end else if (acc && live_press && (key_code == K_NUM)) begin
				num_q <= ~num_q;
			end
			if (acc && live_press && is_shift) begin
				shift_q <= 1'b1;
			end else if (acc && live_release && is_shift) begin
				shift_q <= 1'b0;
			end
			if (acc && op.done) begin
				finished_q <= 1'b1;
			end
		end
	end

	// Character table: written by table items, read for a lookup.
	assign tbl_we    = acc && (op.kind == OP_TABLE) &&
		({1'b0, table_index} < 10'(TBL_DEPTH));
	assign tbl_re    = acc && (op.kind == OP_LOOKUP);
	assign tbl_raddr = TA'({kp.code, cp ^ sh});

	kbd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TBL_DEPTH),
		.AW    (TA)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TA'(table_index)),
		.wdata ({table_valid, table_char}),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

endmodule

// ===== rtl/core/kbd_line.sv =====
module kbd_line #(
	parameter int LINE_DEPTH = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	output logic                        acc,
	input  kbd_pkg::kbd_op_t            op,
	input  logic [6:0]                  read_index,
	input  logic [kbd_pkg::ENTRY_W-1:0] tbl_rdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [7:0]                  line_length,
	output logic [20:0]                 char_out,
	output logic                        entry_done
);
	import kbd_pkg::*;

	localparam int LA = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int FW = $clog2(LINE_DEPTH + 1);
	localparam logic [FW-1:0] DEPTH_F = FW'(LINE_DEPTH);

	logic              valid_s1;
	kbd_op_t           op_s1;
	logic [6:0]        ridx_s1;
	logic              fwd_s1;
	logic [CHAR_W-1:0] fwd_data_s1;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     fill_d;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [CHAR_W-1:0] char_q;
	logic              done_q;
	logic [7:0]        len_q;
	logic              s1_adv;
	logic              commit;
	logic              append;
	logic              line_we;
	logic [LA-1:0]     line_waddr;
	logic [CHAR_W-1:0] line_rdata;
	logic [2:0]        res_status;
	logic [CHAR_W-1:0] res_char;

	// Handshake: the output register parts the stage from the receiver.
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;
	assign acc      = in_valid && !in_stall;
	assign commit   = valid_s1 && s1_adv;

	// Append when the slot is mapped and the line has room.
	assign append     = (op_s1.kind == OP_LOOKUP) && tbl_rdata[VALID_AT] && (fill_q < DEPTH_F);
	assign line_we    = commit && append;
	assign line_waddr = LA'(fill_q);

	// Result and new fill count of the item in the stage.
	always_comb begin
		res_status = ST_IGNORED;
		res_char   = '0;
		fill_d     = fill_q;
		unique case (op_s1.kind)
			OP_NONE:   res_status = ST_IGNORED;
			OP_CLOSED: res_status = ST_CLOSED;
			OP_LOOKUP: begin
				if (append) begin
					res_status = ST_APPENDED;
					res_char   = tbl_rdata[CHAR_W-1:0];
					fill_d     = fill_q + FW'(1);
				end else begin
					res_status = ST_DROPPED;
				end
			end
			OP_ERASE: begin
				res_status = ST_ERASED;
				if (fill_q != '0) begin
					fill_d = fill_q - FW'(1);
				end
			end
			OP_ENTER:  res_status = ST_ENTERED;
			OP_CANCEL: begin
				res_status = ST_CANCELLED;
				fill_d     = '0;
			end
			OP_DROP:   res_status = ST_DROPPED;
			OP_TABLE:  res_status = ST_DONE;
			OP_READ: begin
				res_status = ST_DONE;
				if ((11'(ridx_s1) < 11'(fill_q)) && (11'(ridx_s1) < 11'(LINE_DEPTH))) begin
					res_char = fwd_s1 ? fwd_data_s1 : line_rdata;
				end
			end
			default:   res_status = ST_IGNORED;
		endcase
	end

	// Stage valid and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				fill_q <= fill_d;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Stage payload; a read that meets the write in flight takes its data.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1       <= op;
			ridx_s1     <= read_index;
			fwd_s1      <= line_we && (line_waddr == LA'(read_index));
			fwd_data_s1 <= tbl_rdata[CHAR_W-1:0];
		end
		if (commit) begin
			status_q <= res_status;
			char_q   <= res_char;
			done_q   <= op_s1.done;
			len_q    <= 8'(fill_d);
		end
	end

	// Line buffer.
	kbd_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (LINE_DEPTH),
		.AW    (LA)
	) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (tbl_rdata[CHAR_W-1:0]),
		.re    (acc && (op.kind == OP_READ)),
		.raddr (LA'(read_index)),
		.rdata (line_rdata)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign line_length = len_q;
	assign char_out    = char_q;
	assign entry_done  = done_q;

`ifndef SYNTH
	// The fill count never passes the line depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("fill count beyond line depth");

	// A buffer write grows the line by exactly one.
	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		line_we |=> (fill_q == $past(fill_q) + FW'(1)))
		else $error("append did not grow the line by one");

	// A closed result always reports a finished entry.
	a_closed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_CLOSED)) |-> done_q)
		else $error("closed result without finished entry");

	// An item held in the stage is not lost.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> valid_s1)
		else $error("stalled item dropped from stage");
`endif

endmodule

// ===== rtl/core/keyboard_scancode_line_entry.sv =====
// Keyboard line entry.
// Input channel (in_valid / in_stall) carries one item per accept: a key
// event, a character table write, or a read of one line buffer position.
// Output channel (out_valid / out_stall) returns exactly one result per item,
// in order: status, current line length, a character and the entry-done flag.
// An accepted item is held in the lookup stage while the table or line
// buffer memory is read, then lands in the output register. Throughput:
// one item per cycle while the receiver does not stall, set by the single
// read port of each memory and the read-modify-write of the fill count.
// A line read issued while an append to the same slot is committing is fed
// from the write data.
// Reset clears the modifier state, the fill count and the finished flag at
// once; no memory sweep is needed and items are taken right after reset.
// When the receiver stalls, the output register holds its result, the stage
// behind it fills, and in_stall rises until the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) load the caps and num
// lock state; the user must make them while no item is in flight, unenforced.
module keyboard_scancode_line_entry #(
	parameter int LINE_DEPTH = 128,
	parameter int CODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  key_code,
	input  logic [1:0]  key_action,
	input  logic [8:0]  table_index,
	input  logic [20:0] table_char,
	input  logic        table_valid,
	input  logic [6:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  line_length,
	output logic [20:0] char_out,
	output logic        entry_done
);
	import kbd_pkg::*;

	logic                acc;
	kbd_op_t             op;
	logic [ENTRY_W-1:0]  tbl_rdata;

	// Decode, modifier state and character table.
	kbd_front #(
		.CODE_COUNT (CODE_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.acc         (acc),
		.cmd         (cmd),
		.key_code    (key_code),
		.key_action  (key_action),
		.table_index (table_index),
		.table_char  (table_char),
		.table_valid (table_valid),
		.op          (op),
		.tbl_rdata   (tbl_rdata)
	);

	// Line buffer, fill count and result register.
	kbd_line #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_line (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.acc         (acc),
		.op          (op),
		.read_index  (read_index),
		.tbl_rdata   (tbl_rdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.line_length (line_length),
		.char_out    (char_out),
		.entry_done  (entry_done)
	);

endmodule
